/* hw/rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// shared constants for the pll divider search: field widths, register
// indexes and parameter defaults
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  // parameter defaults
  localparam int unsigned POST_DIV_END_DEF  = 128;
  localparam int unsigned FB_DIV_CEIL_DEF   = 1024;
  localparam int unsigned REF_DIV_START_DEF = 128;

  // field widths
  localparam int unsigned PIX_W      = 20;
  localparam int unsigned RC_W       = 20;
  localparam int unsigned VCO_W      = 22;
  localparam int unsigned REF_OUT_W  = 8;
  localparam int unsigned FB_OUT_W   = 10;
  localparam int unsigned POST_OUT_W = 7;
  localparam int unsigned ERR_W      = 20;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_CLOCK = 2'd0,
    CFG_VCO_MIN   = 2'd1,
    CFG_VCO_MAX   = 2'd2
  } cfg_idx_e;

  localparam logic [RC_W-1:0]  REF_CLOCK_RST = RC_W'(27000);
  localparam logic [VCO_W-1:0] VCO_MIN_RST   = VCO_W'(600000);
  localparam logic [VCO_W-1:0] VCO_MAX_RST   = VCO_W'(1100000);

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

endpackage

`default_nettype wire

/* hw/rtl/pds_div.sv */
// ----------------------------------------------------------------------------
// pds_div
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
`default_nettype none

module pds_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_d, cnt_q;
  logic          done_d, done_q;
  logic [DW-1:0] quo_d, quo_q;
  logic [VW-1:0] rem_d, rem_q;
  logic [VW-1:0] dsr_d, dsr_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      rem_d  = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_d  = {quo_q[DW-2:0], ge};
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/pll_divider_search_top.sv */
// ----------------------------------------------------------------------------
// pll_divider_search_top
// searches post, reference and feedback dividers for a requested pixel clock
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  requested pixel clock
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  found flag, dividers and error
//  cfg       in   cfg_we_i                         ref clock, vco min, vco max
//
//  one word is searched at a time; the input is ready only when idle
//  a candidate with an in-range feedback divider uses the shared DW-bit
//  divider twice (DW = 37 at default parameters), a skipped one once;
//  each post divider adds a vco check; up to 126*127 candidates per word
//  a finished result waits in the output register while the next word
//  is taken; the search holds in its last state until the slot frees
//  reset restores the register defaults and empties the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_search_top #(
  parameter int unsigned POST_DIV_END   = pds_pkg::POST_DIV_END_DEF,
  parameter int unsigned FB_DIV_CEIL    = pds_pkg::FB_DIV_CEIL_DEF,
  parameter int unsigned REF_DIV_START  = pds_pkg::REF_DIV_START_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // pixel_clock_khz [19:0]
  input  wire logic [pds_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // ref_div [7:0], fb_div [17:8], post_div [24:18], clock_error_khz [44:25]
  output logic [pds_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // found [0]
  output logic                                 m_axis_tuser_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PIX_W  = pds_pkg::PIX_W;
  localparam int unsigned RC_W   = pds_pkg::RC_W;
  localparam int unsigned VCO_W  = pds_pkg::VCO_W;
  localparam int unsigned POST_W = $clog2(POST_DIV_END);
  localparam int unsigned REF_W  = $clog2(REF_DIV_START + 1);
  localparam int unsigned FB_W   = $clog2(FB_DIV_CEIL);
  localparam int unsigned VCOP_W = PIX_W + POST_W;
  localparam int unsigned NUM1_W = VCOP_W + REF_W + 2;
  localparam int unsigned NUM2_W = FB_W + RC_W;
  localparam int unsigned DW     = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
  localparam int unsigned VW     = ((RC_W + 1) > (POST_W + REF_W)) ?
                                   (RC_W + 1) : (POST_W + REF_W);
  localparam int unsigned MA_W   = (VCOP_W > FB_W) ? VCOP_W : FB_W;
  localparam int unsigned MB_W0  = (RC_W > REF_W) ? RC_W : REF_W;
  localparam int unsigned MB_W   = (MB_W0 > POST_W) ? MB_W0 : POST_W;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_VCO   = 12'b0000_0000_0010,
    ST_VCHK  = 12'b0000_0000_0100,
    ST_MR    = 12'b0000_0000_1000,
    ST_D1S   = 12'b0000_0001_0000,
    ST_D1    = 12'b0000_0010_0000,
    ST_FBCHK = 12'b0000_0100_0000,
    ST_MF    = 12'b0000_1000_0000,
    ST_MPR   = 12'b0001_0000_0000,
    ST_D2    = 12'b0010_0000_0000,
    ST_ERR   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e state_d, state_q;

  // configuration registers
  logic [RC_W-1:0]  rc_q;
  logic [VCO_W-1:0] vmin_q, vmax_q;

  // search registers
  logic [PIX_W-1:0]  pix_d, pix_q;
  logic [POST_W-1:0] post_d, post_q;
  logic [REF_W-1:0]  ref_d, ref_q;
  logic [FB_W-1:0]   fb_d, fb_q;
  logic [VCOP_W-1:0] vco_d, vco_q;
  logic [DW-1:0]     prod_d, prod_q;
  logic              have_d, have_q;
  logic [DW-1:0]     best_err_d, best_err_q;
  logic [REF_W-1:0]  best_ref_d, best_ref_q;
  logic [FB_W-1:0]   best_fb_d, best_fb_q;
  logic [POST_W-1:0] best_post_d, best_post_q;

  // output register
  logic                            out_valid_d, out_valid_q;
  logic                            out_found_d, out_found_q;
  logic [pds_pkg::REF_OUT_W-1:0]   out_ref_d, out_ref_q;
  logic [pds_pkg::FB_OUT_W-1:0]    out_fb_d, out_fb_q;
  logic [pds_pkg::POST_OUT_W-1:0]  out_post_d, out_post_q;
  logic [pds_pkg::ERR_W-1:0]       out_err_d, out_err_q;

  // shared multiplier and divider
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [MA_W+MB_W-1:0] mul_p;
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [VW-1:0]        div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quot;

  logic          in_acc;
  logic          last_post, last_ref;
  logic [DW-1:0] pix_ext, err;
  logic          better;

  assign mul_p = mul_a * mul_b;

  pds_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_post       = (post_q == POST_W'(POST_DIV_END - 1));
  assign last_ref        = (ref_q == REF_W'(2));
  assign pix_ext         = DW'(pix_q);
  assign err             = (pix_ext >= div_quot) ? (pix_ext - div_quot) : (div_quot - pix_ext);
  assign better          = !have_q || (err < best_err_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= pds_pkg::REF_CLOCK_RST;
      vmin_q <= pds_pkg::VCO_MIN_RST;
      vmax_q <= pds_pkg::VCO_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pds_pkg::CFG_REF_CLOCK: rc_q   <= cfg_data_i[RC_W-1:0];
        pds_pkg::CFG_VCO_MIN:   vmin_q <= cfg_data_i[VCO_W-1:0];
        pds_pkg::CFG_VCO_MAX:   vmax_q <= cfg_data_i[VCO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    pix_d        = pix_q;
    post_d       = post_q;
    ref_d        = ref_q;
    fb_d         = fb_q;
    vco_d        = vco_q;
    prod_d       = prod_q;
    have_d       = have_q;
    best_err_d   = best_err_q;
    best_ref_d   = best_ref_q;
    best_fb_d    = best_fb_q;
    best_post_d  = best_post_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_found_d  = out_found_q;
    out_ref_d    = out_ref_q;
    out_fb_d     = out_fb_q;
    out_post_d   = out_post_q;
    out_err_d    = out_err_q;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pix_d   = s_axis_tdata_i[PIX_W-1:0];
          post_d  = POST_W'(2);
          have_d  = 1'b0;
          state_d = (rc_q == '0) ? ST_DONE : ST_VCO;
        end
      end
      ST_VCO: begin
        mul_a   = MA_W'(pix_q);
        mul_b   = MB_W'(post_q);
        prod_d  = DW'(mul_p);
        state_d = ST_VCHK;
      end
      ST_VCHK: begin
        vco_d = prod_q[VCOP_W-1:0];
        ref_d = REF_W'(REF_DIV_START);
        if (prod_q < DW'(vmin_q)) begin
          if (last_post) begin
            state_d = ST_DONE;
          end else begin
            post_d  = post_q + POST_W'(1);
            state_d = ST_VCO;
          end
        end else if (prod_q > DW'(vmax_q)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MR;
        end
      end
      ST_MR: begin
        mul_a   = MA_W'(vco_q);
        mul_b   = MB_W'(ref_q);
        prod_d  = DW'(mul_p);
        state_d = ST_D1S;
      end
      ST_D1S: begin
        div_start    = 1'b1;
        div_dividend = {prod_q[DW-2:0], 1'b0} + DW'(rc_q);
        div_divisor  = VW'({rc_q, 1'b0});
        state_d      = ST_D1;
      end
      ST_D1: begin
        if (div_done) begin
          state_d = ST_FBCHK;
        end
      end
      ST_FBCHK: begin
        if (div_quot == '0) begin
          if (last_post) begin
            state_d = ST_DONE;
          end else begin
            post_d  = post_q + POST_W'(1);
            state_d = ST_VCO;
          end
        end else if (div_quot >= DW'(FB_DIV_CEIL)) begin
          if (last_ref) begin
            if (last_post) begin
              state_d = ST_DONE;
            end else begin
              post_d  = post_q + POST_W'(1);
              state_d = ST_VCO;
            end
          end else begin
            ref_d   = ref_q - REF_W'(1);
            state_d = ST_MR;
          end
        end else begin
          fb_d    = div_quot[FB_W-1:0];
          state_d = ST_MF;
        end
      end
      ST_MF: begin
        mul_a   = MA_W'(fb_q);
        mul_b   = MB_W'(rc_q);
        prod_d  = DW'(mul_p);
        state_d = ST_MPR;
      end
      ST_MPR: begin
        mul_a        = MA_W'(post_q);
        mul_b        = MB_W'(ref_q);
        div_start    = 1'b1;
        div_dividend = prod_q;
        div_divisor  = VW'(mul_p);
        state_d      = ST_D2;
      end
      ST_D2: begin
        if (div_done) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        if (better) begin
          have_d      = 1'b1;
          best_err_d  = err;
          best_ref_d  = ref_q;
          best_fb_d   = fb_q;
          best_post_d = post_q;
        end
        if ((better && err == '0) || (!better && best_err_q == '0)) begin
          state_d = ST_DONE;
        end else if (last_ref) begin
          if (last_post) begin
            state_d = ST_DONE;
          end else begin
            post_d  = post_q + POST_W'(1);
            state_d = ST_VCO;
          end
        end else begin
          ref_d   = ref_q - REF_W'(1);
          state_d = ST_MR;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_found_d = have_q;
          if (have_q) begin
            out_ref_d  = pds_pkg::REF_OUT_W'(best_ref_q);
            out_fb_d   = pds_pkg::FB_OUT_W'(best_fb_q);
            out_post_d = pds_pkg::POST_OUT_W'(best_post_q);
            out_err_d  = (best_err_q > DW'(pds_pkg::ERR_MAX)) ? pds_pkg::ERR_MAX :
                         best_err_q[pds_pkg::ERR_W-1:0];
          end else begin
            out_ref_d  = '0;
            out_fb_d   = '0;
            out_post_d = '0;
            out_err_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      post_q      <= POST_W'(2);
      ref_q       <= REF_W'(REF_DIV_START);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
      post_q      <= post_d;
      ref_q       <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q       <= pix_d;
    fb_q        <= fb_d;
    vco_q       <= vco_d;
    prod_q      <= prod_d;
    best_err_q  <= best_err_d;
    best_ref_q  <= best_ref_d;
    best_fb_q   <= best_fb_d;
    best_post_q <= best_post_d;
    out_found_q <= out_found_d;
    out_ref_q   <= out_ref_d;
    out_fb_q    <= out_fb_d;
    out_post_q  <= out_post_d;
    out_err_q   <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tdata_o  = pds_pkg::OUT_DATA_W'({out_err_q, out_post_q, out_fb_q, out_ref_q});

endmodule

`default_nettype wire
